FILE: sv/escape_time_fractal_hsv_pixel_top_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the escape-time fractal pixel block
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef ESCAPE_TIME_FRACTAL_HSV_PIXEL_TOP_MACROS_SVH
`define ESCAPE_TIME_FRACTAL_HSV_PIXEL_TOP_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define ETF_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define ETF_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: sv/etfhsv_pkg.sv
// ----------------------------------------------------------------------------
// Escape-time fractal pixel package
// Widths, register indexes, state and interface types, and the hue mapping.
// ----------------------------------------------------------------------------
package etfhsv_pkg;

    localparam int COORD_BITS = 11;
    localparam int FRAC_BITS  = 28;
    localparam int Z_W        = 32;
    localparam int ACC_W      = Z_W + FRAC_BITS;
    localparam int CNT_W      = 8;
    localparam int COLOR_W    = 8;
    localparam int STEP_W     = 31;
    localparam int HUE_T_W    = CNT_W + 3;
    localparam int DIV_W      = 16;
    localparam int DEN_W      = 8;
    localparam int DIV_CNT_W  = $clog2(DIV_W);
    localparam int IN_W       = 24;
    localparam int OUT_W      = 32;
    localparam int CFG_ADDR_W = 3;

    localparam logic [Z_W-1:0]    C_RE_RST     = 32'd76504105;
    localparam logic [Z_W-1:0]    C_IM_RST     = 32'd2684355;
    localparam logic [CNT_W-1:0]  MAX_ITER_RST = 8'd90;
    localparam logic [Z_W-1:0]    RE_MIN_RST   = 32'hECCC_CCCD;
    localparam logic [Z_W-1:0]    IM_MIN_RST   = 32'hECCC_CCCD;
    localparam logic [STEP_W-1:0] RE_STEP_RST  = 31'd805306;
    localparam logic [STEP_W-1:0] IM_STEP_RST  = 31'd805306;

    localparam logic [COLOR_W-1:0] COLOR_FULL = 8'd255;

    typedef enum logic [CFG_ADDR_W-1:0] {
        CFG_C_RE     = 3'd0,
        CFG_C_IM     = 3'd1,
        CFG_MAX_ITER = 3'd2,
        CFG_RE_MIN   = 3'd3,
        CFG_IM_MIN   = 3'd4,
        CFG_RE_STEP  = 3'd5,
        CFG_IM_STEP  = 3'd6
    } cfg_index_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MAP,
        ST_INIT,
        ST_SQR,
        ST_CHK,
        ST_DIV_SEC,
        ST_DIV_FRAC,
        ST_OUT
    } state_t;

    typedef enum logic [2:0] {
        SEC_R2Y = 3'd0,
        SEC_Y2G = 3'd1,
        SEC_G2C = 3'd2,
        SEC_C2B = 3'd3,
        SEC_B2M = 3'd4,
        SEC_M2R = 3'd5
    } sector_t;

    typedef struct packed {
        logic [COLOR_W-1:0] blue;
        logic [COLOR_W-1:0] green;
        logic [COLOR_W-1:0] red;
    } rgb_t;

    typedef struct packed {
        logic signed [Z_W-1:0] x0;
        logic signed [Z_W-1:0] y0;
        logic signed [Z_W-1:0] x1;
        logic signed [Z_W-1:0] y1;
    } cmul_op_t;

    typedef struct packed {
        logic signed [2*Z_W-1:0] p0;
        logic signed [2*Z_W-1:0] p1;
        logic signed [2*Z_W-1:0] p2;
    } cmul_res_t;

    typedef struct packed {
        logic             start;
        logic [DIV_W-1:0] dividend;
        logic [DEN_W-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic             done;
        logic [DIV_W-1:0] quotient;
        logic [DEN_W-1:0] remainder;
    } div_rsp_t;

    // Fully saturated hue: one channel at full scale, one ramping, one off.
    function automatic rgb_t hue_rgb(input sector_t sector, input logic [COLOR_W-1:0] rise);
        rgb_t               c;
        logic [COLOR_W-1:0] fall;
        fall = COLOR_FULL - rise;
        c    = '0;
        case (sector)
            SEC_R2Y: begin c.red = COLOR_FULL; c.green = rise; end
            SEC_Y2G: begin c.red = fall; c.green = COLOR_FULL; end
            SEC_G2C: begin c.green = COLOR_FULL; c.blue = rise; end
            SEC_C2B: begin c.green = fall; c.blue = COLOR_FULL; end
            SEC_B2M: begin c.red = rise; c.blue = COLOR_FULL; end
            SEC_M2R: begin c.red = COLOR_FULL; c.blue = fall; end
            default: begin c.red = COLOR_FULL; c.blue = fall; end
        endcase
        return c;
    endfunction

endpackage

FILE: sv/etfhsv_cmul.sv
// ----------------------------------------------------------------------------
// Shared product unit
// Three registered signed 32x32 products: x0*y0, x1*y1 and x0*y1.
// ----------------------------------------------------------------------------
module etfhsv_cmul
    import etfhsv_pkg::*;
(
    input  logic      clk,
    input  cmul_op_t  op,
    output cmul_res_t res
);

    cmul_res_t res_reg;
    cmul_res_t res_next;

    always_comb
    begin
        res_next.p0 = op.x0 * op.y0;
        res_next.p1 = op.x1 * op.y1;
        res_next.p2 = op.x0 * op.y1;
    end

    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
    end

    assign res = res_reg;

endmodule

FILE: sv/etfhsv_div.sv
// ----------------------------------------------------------------------------
// Serial divider
// Restoring division, one quotient bit per cycle, with a one-cycle done pulse.
// ----------------------------------------------------------------------------
module etfhsv_div
    import etfhsv_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  div_req_t req,
    output div_rsp_t rsp
);

    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic [DIV_W-1:0]     quo_reg, quo_next;
    logic [DEN_W-1:0]     rem_reg, rem_next;
    logic [DEN_W-1:0]     den_reg, den_next;
    logic [DEN_W:0]       shifted;
    logic [DEN_W:0]       diff;
    logic                 ge;

    assign shifted = {rem_reg, quo_reg[DIV_W-1]};
    assign ge      = shifted >= {1'b0, den_reg};
    assign diff    = shifted - {1'b0, den_reg};

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        if (req.start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            quo_next  = req.dividend;
            rem_next  = '0;
            den_next  = req.divisor;
        end
        else if (busy_reg)
        begin
            quo_next = {quo_reg[DIV_W-2:0], ge};
            rem_next = ge ? diff[DEN_W-1:0] : shifted[DEN_W-1:0];
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == DIV_CNT_W'(DIV_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        den_reg <= den_next;
    end

    assign rsp.done      = done_reg;
    assign rsp.quotient  = quo_reg;
    assign rsp.remainder = rem_reg;

endmodule

FILE: sv/escape_time_fractal_hsv_pixel_top.sv
// Each iteration is one pass through the shared product unit (ST_SQR, then ST_CHK);
// the hue takes two serial divisions. One pixel is in work at a time, so a new
// transaction is accepted in the cycle after the result is loaded.
// Reset (rst_n, asynchronous, active low) idles the sequencer and loads the default view.
// ----------------------------------------------------------------------------
// Escape-time fractal pixel
// Maps a pixel to a start point, iterates z = z*z + c and colors the result.
// ----------------------------------------------------------------------------
`include "escape_time_fractal_hsv_pixel_top_macros.svh"

module escape_time_fractal_hsv_pixel_top
    import etfhsv_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [Z_W-1:0]        cfg_wdata,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [IN_W-1:0]       s_axis_tdata,   // px [10:0], py [21:11], zero pad
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [OUT_W-1:0]      m_axis_tdata,   // red, green, blue, iterations
    output logic                  m_axis_tuser    // escaped
);

    localparam logic [2*Z_W-1:0] ESC_LIMIT = 64'd4 << (2 * FRAC_BITS);

    // Configuration registers
    logic [Z_W-1:0]    c_re_reg, c_im_reg, re_min_reg, im_min_reg;
    logic [CNT_W-1:0]  max_iter_reg;
    logic [STEP_W-1:0] re_step_reg, im_step_reg;

    // Sequencer state
    state_t             state_reg, state_next;
    logic [COORD_BITS-1:0] px_reg, px_next, py_reg, py_next;
    logic [CNT_W-1:0]   lim_reg, lim_next;
    logic [CNT_W-1:0]   iter_reg, iter_next;
    logic [Z_W-1:0]     zr_reg, zr_next, zi_reg, zi_next;
    logic               esc_reg, esc_next;
    sector_t            sector_reg, sector_next;
    rgb_t               rgb_reg, rgb_next;
    logic               m_valid_reg, m_valid_next;
    logic [OUT_W-1:0]   m_data_reg, m_data_next;
    logic               m_user_reg, m_user_next;

    cmul_op_t           mul_op;
    cmul_res_t          mul_res;
    div_req_t           div_req;
    div_rsp_t           div_rsp;

    logic [2*Z_W-1:0]   sq_sum;
    logic               escape;
    logic [ACC_W-1:0]   re_acc;
    logic [ACC_W-2:0]   im_acc;
    logic [HUE_T_W-1:0] hue_t;
    logic [DIV_W-1:0]   frac_scaled;
    logic [CNT_W-1:0]   iter_inc;

    etfhsv_cmul u_cmul (
        .clk (clk),
        .op  (mul_op),
        .res (mul_res)
    );

    etfhsv_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            c_re_reg     <= C_RE_RST;
            c_im_reg     <= C_IM_RST;
            max_iter_reg <= MAX_ITER_RST;
            re_min_reg   <= RE_MIN_RST;
            im_min_reg   <= IM_MIN_RST;
            re_step_reg  <= RE_STEP_RST;
            im_step_reg  <= IM_STEP_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_addr)
                CFG_C_RE:     c_re_reg     <= cfg_wdata;
                CFG_C_IM:     c_im_reg     <= cfg_wdata;
                CFG_MAX_ITER: max_iter_reg <= cfg_wdata[CNT_W-1:0];
                CFG_RE_MIN:   re_min_reg   <= cfg_wdata;
                CFG_IM_MIN:   im_min_reg   <= cfg_wdata;
                CFG_RE_STEP:  re_step_reg  <= cfg_wdata[STEP_W-1:0];
                CFG_IM_STEP:  im_step_reg  <= cfg_wdata[STEP_W-1:0];
                default:      ;
            endcase
        end
    end

    // Both squares are non-negative, so their sum cannot wrap in 64 bits.
    assign sq_sum = mul_res.p0 + mul_res.p1;
    assign escape = sq_sum >= ESC_LIMIT;

    // c is aligned to the product's binary point before the shift; the floor shift is then a bit select.
    assign re_acc = mul_res.p0[ACC_W-1:0] - mul_res.p1[ACC_W-1:0]
                  + {c_re_reg, {FRAC_BITS{1'b0}}};
    assign im_acc = mul_res.p2[ACC_W-2:0] + {c_im_reg, {(FRAC_BITS-1){1'b0}}};

    assign hue_t       = {1'b0, iter_reg, 2'b00} + {2'b00, iter_reg, 1'b0};
    assign frac_scaled = {div_rsp.remainder, {DEN_W{1'b0}}}
                       - {{(DIV_W-DEN_W){1'b0}}, div_rsp.remainder};
    assign iter_inc    = iter_reg + 1'b1;

    always_comb
    begin
        state_next   = state_reg;
        px_next      = px_reg;
        py_next      = py_reg;
        lim_next     = lim_reg;
        iter_next    = iter_reg;
        zr_next      = zr_reg;
        zi_next      = zi_reg;
        esc_next     = esc_reg;
        sector_next  = sector_reg;
        rgb_next     = rgb_reg;
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        m_user_next  = m_user_reg;

        mul_op.x0 = zr_reg;
        mul_op.y0 = zr_reg;
        mul_op.x1 = zi_reg;
        mul_op.y1 = zi_reg;

        div_req.start    = 1'b0;
        div_req.dividend = {{(DIV_W-HUE_T_W){1'b0}}, hue_t};
        div_req.divisor  = lim_reg;

        if (m_axis_tready)
        begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    px_next    = s_axis_tdata[COORD_BITS-1:0];
                    py_next    = s_axis_tdata[2*COORD_BITS-1:COORD_BITS];
                    lim_next   = max_iter_reg;
                    iter_next  = '0;
                    state_next = ST_MAP;
                end
            end
            ST_MAP:
            begin
                mul_op.x0  = {{(Z_W-COORD_BITS){1'b0}}, px_reg};
                mul_op.y0  = {1'b0, re_step_reg};
                mul_op.x1  = {{(Z_W-COORD_BITS){1'b0}}, py_reg};
                mul_op.y1  = {1'b0, im_step_reg};
                state_next = ST_INIT;
            end
            ST_INIT:
            begin
                zr_next  = re_min_reg + mul_res.p0[Z_W-1:0];
                zi_next  = im_min_reg + mul_res.p1[Z_W-1:0];
                esc_next = 1'b0;
                rgb_next = '0;
                if (lim_reg == '0)
                begin
                    state_next = ST_OUT;
                end
                else
                begin
                    state_next = ST_SQR;
                end
            end
            ST_SQR:
            begin
                state_next = ST_CHK;
            end
            ST_CHK:
            begin
                if (escape)
                begin
                    esc_next      = 1'b1;
                    div_req.start = 1'b1;
                    state_next    = ST_DIV_SEC;
                end
                else
                begin
                    zr_next   = re_acc[ACC_W-1:FRAC_BITS];
                    zi_next   = im_acc[ACC_W-2:FRAC_BITS-1];
                    iter_next = iter_inc;
                    if (iter_inc == lim_reg)
                    begin
                        state_next = ST_OUT;
                    end
                    else
                    begin
                        state_next = ST_SQR;
                    end
                end
            end
            ST_DIV_SEC:
            begin
                if (div_rsp.done)
                begin
                    sector_next      = sector_t'(div_rsp.quotient[2:0]);
                    div_req.start    = 1'b1;
                    div_req.dividend = frac_scaled;
                    state_next       = ST_DIV_FRAC;
                end
            end
            ST_DIV_FRAC:
            begin
                if (div_rsp.done)
                begin
                    rgb_next   = hue_rgb(sector_reg, div_rsp.quotient[COLOR_W-1:0]);
                    state_next = ST_OUT;
                end
            end
            ST_OUT:
            begin
                if (!m_valid_reg || m_axis_tready)
                begin
                    m_valid_next = 1'b1;
                    m_data_next  = {iter_reg, rgb_reg};
                    m_user_next  = esc_reg;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
            lim_reg     <= '0;
            iter_reg    <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
            lim_reg     <= lim_next;
            iter_reg    <= iter_next;
        end
    end

    always_ff @(posedge clk)
    begin
        px_reg     <= px_next;
        py_reg     <= py_next;
        zr_reg     <= zr_next;
        zi_reg     <= zi_next;
        esc_reg    <= esc_next;
        sector_reg <= sector_next;
        rgb_reg    <= rgb_next;
        m_data_reg <= m_data_next;
        m_user_reg <= m_user_next;
    end

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;
    assign m_axis_tuser  = m_user_reg;

    `ETF_ASSERT_SAME(a_chk_below_limit, state_reg == ST_CHK, iter_reg < lim_reg,
        "escape test reached with the iteration count at the limit")
    `ETF_ASSERT_SAME(a_sector_range, (state_reg == ST_DIV_SEC) && div_rsp.done,
        div_rsp.quotient < DIV_W'(6), "hue sector out of range")
    `ETF_ASSERT_SAME(a_bounded_black, m_axis_tvalid && !m_axis_tuser,
        m_axis_tdata[3*COLOR_W-1:0] == '0, "bounded pixel is not black")
    `ETF_ASSERT_NEXT(a_busy_after_accept, s_axis_tvalid && s_axis_tready, !s_axis_tready,
        "ready while a pixel is in work")

endmodule
